[design/ethernet_ipv4_l4_header_parser_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet / IPv4 / L4 header parser.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IPV4_L4_HEADER_PARSER_DEFINES_SVH
`define ETHERNET_IPV4_L4_HEADER_PARSER_DEFINES_SVH

// Checked property, disabled while reset is asserted.
`define EIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, also evaluated during reset.
`define EIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/eip_pkg.sv]
// ----------------------------------------------------------------------------
// eip_pkg
// Field codes, protocol constants and result type for the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package eip_pkg;

    // Field identifiers carried on field_id
    localparam logic [4:0] FID_SRCIP    = 5'd0;
    localparam logic [4:0] FID_DSTIP    = 5'd1;
    localparam logic [4:0] FID_TOS      = 5'd2;
    localparam logic [4:0] FID_DFMF     = 5'd3;
    localparam logic [4:0] FID_TTL      = 5'd4;
    localparam logic [4:0] FID_PROTO    = 5'd5;
    localparam logic [4:0] FID_SPORT    = 5'd6;
    localparam logic [4:0] FID_DPORT    = 5'd7;
    localparam logic [4:0] FID_SEQ      = 5'd8;
    localparam logic [4:0] FID_ACK      = 5'd9;
    localparam logic [4:0] FID_TCPFLAGS = 5'd10;
    localparam logic [4:0] FID_WIN      = 5'd11;
    localparam logic [4:0] FID_ICMPTYPE = 5'd12;
    localparam logic [4:0] FID_ICMPCODE = 5'd13;
    localparam logic [4:0] FID_PAYSIZE  = 5'd14;
    localparam logic [4:0] FID_PAYBYTE  = 5'd15;
    localparam logic [4:0] FID_END      = 5'd16;

    // Ethernet / IP constants
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] OFF_ETYPE_LO  = 16'd13;
    localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [5:0]  TCP_HDR_MIN   = 6'd20;
    localparam logic [5:0]  SHORT_L4_HDR  = 6'd8;
    localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

    // Byte offsets within the IPv4 header region of the frame
    localparam logic [15:0] OFF_IP_TOS    = 16'd15;
    localparam logic [15:0] OFF_IP_LEN_LO = 16'd17;
    localparam logic [15:0] OFF_IP_FLAGS  = 16'd20;
    localparam logic [15:0] OFF_IP_TTL    = 16'd22;
    localparam logic [15:0] OFF_IP_PROTO  = 16'd23;
    localparam logic [15:0] OFF_IP_SRC_LO = 16'd29;
    localparam logic [15:0] OFF_IP_DST_LO = 16'd33;

    // Byte offsets relative to the start of the L4 header
    localparam logic [15:0] REL_SPORT_LO = 16'd1;
    localparam logic [15:0] REL_DPORT_LO = 16'd3;
    localparam logic [15:0] REL_UDPLEN   = 16'd5;
    localparam logic [15:0] REL_SEQ_LO   = 16'd7;
    localparam logic [15:0] REL_ACK_LO   = 16'd11;
    localparam logic [15:0] REL_DOFF     = 16'd12;
    localparam logic [15:0] REL_FLAGS    = 16'd13;
    localparam logic [15:0] REL_WIN_LO   = 16'd15;
    localparam logic [15:0] REL_ICMPTYPE = 16'd0;
    localparam logic [15:0] REL_ICMPCODE = 16'd1;

    // One result item
    typedef struct packed {
        logic [4:0]  id;
        logic [31:0] value;
        logic        done;
    } result_t;

    // Saturating subtract, floors at zero
    function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : 16'd0;
    endfunction

endpackage

`default_nettype wire

[design/ethernet_ipv4_l4_header_parser.sv]
// ----------------------------------------------------------------------------
// ethernet_ipv4_l4_header_parser: byte-wide Ethernet/IPv4/TCP-UDP-ICMP parser
// Results are registered: in the output register, or in the skid stage while the output is held.
// Throughput: one byte per cycle while in_stall is low; in_stall is high while the skid stage is full.
// Reset: asynchronous, active low; clears parse state and empties the outputs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ethernet_ipv4_l4_header_parser_defines.svh"

module ethernet_ipv4_l4_header_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        frame_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       field_id,
    output logic [31:0]      field_value,
    output logic             frame_done
);
    import eip_pkg::*;

    // Parse state
    logic [15:0] byte_offset_reg,       byte_offset_next;
    logic [15:0] ether_kind_reg,        ether_kind_next;
    logic [5:0]  ip_hdr_bytes_reg,      ip_hdr_bytes_next;
    logic [15:0] ip_total_len_reg,      ip_total_len_next;
    logic [7:0]  l4_proto_reg,          l4_proto_next;
    logic [5:0]  l4_hdr_bytes_reg,      l4_hdr_bytes_next;
    logic [15:0] payload_remaining_reg, payload_remaining_next;
    logic [31:0] field_accum_reg,       field_accum_next;

    // Output register and skid stage
    result_t out_reg, skid_reg, res_new;
    logic    out_valid_reg, skid_valid_reg;

    logic accept, out_fire, push, have;
    logic [31:0] acc;
    logic [16:0] ip_end;
    logic [15:0] rel;
    logic [3:0]  ihl, doff;
    logic [6:0]  hdr_sum;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    // Field extraction and next parse state for the accepted byte
    always_comb
    begin
        acc                    = {field_accum_reg[23:0], frame_byte};
        byte_offset_next       = byte_offset_reg;
        ether_kind_next        = ether_kind_reg;
        ip_hdr_bytes_next      = ip_hdr_bytes_reg;
        ip_total_len_next      = ip_total_len_reg;
        l4_proto_next          = l4_proto_reg;
        l4_hdr_bytes_next      = l4_hdr_bytes_reg;
        payload_remaining_next = payload_remaining_reg;
        field_accum_next       = acc;
        have                   = 1'b0;
        res_new                = '{id: FID_END, value: 32'd0, done: frame_end};
        ip_end                 = {1'b0, ETH_HDR_LEN} + {11'd0, ip_hdr_bytes_reg};
        rel                    = byte_offset_reg - ip_end[15:0];
        ihl                    = (frame_byte[3:0] < MIN_HDR_WORDS) ? MIN_HDR_WORDS
                                                                   : frame_byte[3:0];
        doff                   = (frame_byte[7:4] < MIN_HDR_WORDS) ? MIN_HDR_WORDS
                                                                   : frame_byte[7:4];
        hdr_sum                = {1'b0, ip_hdr_bytes_reg} + {1'b0, doff, 2'b00};

        if (byte_offset_reg == OFF_ETYPE_LO)
        begin
            ether_kind_next = acc[15:0];
        end
        else if (ether_kind_reg == ETH_TYPE_IPV4 && byte_offset_reg >= ETH_HDR_LEN)
        begin
            if (byte_offset_reg == ETH_HDR_LEN)
            begin
                ip_hdr_bytes_next = {ihl, 2'b00};
            end
            else if ({1'b0, byte_offset_reg} < ip_end)
            begin
                // IPv4 header fields
                case (byte_offset_reg)
                    OFF_IP_TOS:    begin have = 1'b1; res_new.id = FID_TOS;
                                         res_new.value = {24'd0, frame_byte}; end
                    OFF_IP_LEN_LO: ip_total_len_next = acc[15:0];
                    OFF_IP_FLAGS:  begin have = 1'b1; res_new.id = FID_DFMF;
                                         res_new.value = {30'd0, frame_byte[6:5]}; end
                    OFF_IP_TTL:    begin have = 1'b1; res_new.id = FID_TTL;
                                         res_new.value = {24'd0, frame_byte}; end
                    OFF_IP_PROTO:
                    begin
                        l4_proto_next = frame_byte;
                        if (frame_byte == PROTO_TCP)
                            l4_hdr_bytes_next = TCP_HDR_MIN;
                        else if (frame_byte == PROTO_UDP || frame_byte == PROTO_ICMP)
                            l4_hdr_bytes_next = SHORT_L4_HDR;
                        else
                            l4_hdr_bytes_next = 6'd0;
                        have          = 1'b1;
                        res_new.id    = FID_PROTO;
                        res_new.value = {24'd0, frame_byte};
                    end
                    OFF_IP_SRC_LO: begin have = 1'b1; res_new.id = FID_SRCIP;
                                         res_new.value = acc; end
                    OFF_IP_DST_LO: begin have = 1'b1; res_new.id = FID_DSTIP;
                                         res_new.value = acc; end
                    default: ;
                endcase
            end
            else if (l4_hdr_bytes_reg != 6'd0)
            begin
                if (rel < {10'd0, l4_hdr_bytes_reg})
                begin
                    // L4 header fields
                    if (l4_proto_reg == PROTO_TCP)
                    begin
                        case (rel)
                            REL_SPORT_LO: begin have = 1'b1; res_new.id = FID_SPORT;
                                                res_new.value = {16'd0, acc[15:0]}; end
                            REL_DPORT_LO: begin have = 1'b1; res_new.id = FID_DPORT;
                                                res_new.value = {16'd0, acc[15:0]}; end
                            REL_SEQ_LO:   begin have = 1'b1; res_new.id = FID_SEQ;
                                                res_new.value = acc; end
                            REL_ACK_LO:   begin have = 1'b1; res_new.id = FID_ACK;
                                                res_new.value = acc; end
                            REL_DOFF:
                            begin
                                l4_hdr_bytes_next      = {doff, 2'b00};
                                payload_remaining_next = sat_sub(ip_total_len_reg,
                                                                 {9'd0, hdr_sum});
                            end
                            REL_FLAGS:    begin have = 1'b1; res_new.id = FID_TCPFLAGS;
                                                res_new.value = {26'd0, frame_byte[5:0]}; end
                            REL_WIN_LO:   begin have = 1'b1; res_new.id = FID_WIN;
                                                res_new.value = {16'd0, acc[15:0]}; end
                            default: ;
                        endcase
                    end
                    else if (l4_proto_reg == PROTO_UDP)
                    begin
                        case (rel)
                            REL_SPORT_LO: begin have = 1'b1; res_new.id = FID_SPORT;
                                                res_new.value = {16'd0, acc[15:0]}; end
                            REL_DPORT_LO: begin have = 1'b1; res_new.id = FID_DPORT;
                                                res_new.value = {16'd0, acc[15:0]}; end
                            REL_UDPLEN:   payload_remaining_next =
                                              sat_sub(acc[15:0], {10'd0, SHORT_L4_HDR});
                            default: ;
                        endcase
                    end
                    else
                    begin
                        if (rel == REL_ICMPTYPE)
                        begin
                            payload_remaining_next = sat_sub(ip_total_len_reg,
                                {10'd0, ip_hdr_bytes_reg} + {10'd0, SHORT_L4_HDR});
                            have          = 1'b1;
                            res_new.id    = FID_ICMPTYPE;
                            res_new.value = {24'd0, frame_byte};
                        end
                        else if (rel == REL_ICMPCODE)
                        begin
                            have          = 1'b1;
                            res_new.id    = FID_ICMPCODE;
                            res_new.value = {24'd0, frame_byte};
                        end
                    end
                    // Last header byte: report payload size
                    if (rel + 16'd1 == {10'd0, l4_hdr_bytes_next})
                    begin
                        have          = 1'b1;
                        res_new.id    = FID_PAYSIZE;
                        res_new.value = {16'd0, payload_remaining_next};
                    end
                end
                else if (payload_remaining_reg != 16'd0)
                begin
                    payload_remaining_next = payload_remaining_reg - 16'd1;
                    have                   = 1'b1;
                    res_new.id             = FID_PAYBYTE;
                    res_new.value          = {24'd0, frame_byte};
                end
            end
        end

        // Frame end clears everything; otherwise advance the offset, saturating at 16'hFFFF
        if (frame_end)
        begin
            byte_offset_next       = 16'd0;
            ether_kind_next        = 16'd0;
            ip_hdr_bytes_next      = 6'd0;
            ip_total_len_next      = 16'd0;
            l4_proto_next          = 8'd0;
            l4_hdr_bytes_next      = 6'd0;
            payload_remaining_next = 16'd0;
            field_accum_next       = 32'd0;
        end
        else if (byte_offset_reg != 16'hFFFF)
        begin
            byte_offset_next = byte_offset_reg + 16'd1;
        end
    end

    assign push = accept && (have || frame_end);

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg       <= 16'd0;
            ether_kind_reg        <= 16'd0;
            ip_hdr_bytes_reg      <= 6'd0;
            ip_total_len_reg      <= 16'd0;
            l4_proto_reg          <= 8'd0;
            l4_hdr_bytes_reg      <= 6'd0;
            payload_remaining_reg <= 16'd0;
            field_accum_reg       <= 32'd0;
        end
        else if (accept)
        begin
            byte_offset_reg       <= byte_offset_next;
            ether_kind_reg        <= ether_kind_next;
            ip_hdr_bytes_reg      <= ip_hdr_bytes_next;
            ip_total_len_reg      <= ip_total_len_next;
            l4_proto_reg          <= l4_proto_next;
            l4_hdr_bytes_reg      <= l4_hdr_bytes_next;
            payload_remaining_reg <= payload_remaining_next;
            field_accum_reg       <= field_accum_next;
        end
    end

    // Output register with skid stage; stall is the skid occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !out_fire)
                skid_reg <= res_new;
            else
                out_reg <= res_new;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_id    = out_reg.id;
    assign field_value = out_reg.value;
    assign frame_done  = out_reg.done;

    // Checks
    `EIP_ASSERT_ALWAYS(a_skid_needs_out, (skid_valid_reg |-> out_valid_reg),
        "skid holds an item while the output register is empty")
    `EIP_ASSERT(a_end_gives_result, (accept && frame_end |=> out_valid),
        "frame end produced no result")
    `EIP_ASSERT(a_end_clears_offset, (accept && frame_end |=> byte_offset_reg == 16'd0),
        "offset not cleared after frame end")
    `EIP_ASSERT(a_ip_hdr_len, (ip_hdr_bytes_reg == 6'd0 || ip_hdr_bytes_reg >= TCP_HDR_MIN),
        "IPv4 header length below minimum")
    `EIP_ASSERT(a_paybyte_narrow,
        (out_valid && field_id == FID_PAYBYTE |-> field_value[31:8] == 24'd0),
        "payload byte wider than eight bits")

endmodule

`default_nettype wire
